[rtl/binary_min_heap_priority_queue_assert.svh]
// assertion macros for the binary min-heap priority queue
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH
`define BMH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bmh assertion failed");
`define BMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bmh assertion failed");
`else
`define BMH_ASSERT(lbl, prop)
`define BMH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/bmh_pkg.sv]
// shared types and constants for the binary min-heap priority queue
package bmh_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 2;
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic accept;
    logic ins_start;
    logic rem_start;
    logic load_key;
    logic rd_parent;
    logic rd_children;
    logic wr_key;
    logic wr_parent;
    logic wr_child;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_less;
    logic leaf;
    logic child_wins;
  } sts_t;

endpackage

[rtl/bmh_datapath.sv]
// heap memory, sift registers, key comparators and result registers
`include "binary_min_heap_priority_queue_assert.svh"

module bmh_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bmh_pkg::cmd_t                    cmd_i,
  output bmh_pkg::sts_t                    sts_o,
  input  logic                             in_opcode_i,
  input  logic signed [bmh_pkg::KEY_W-1:0] in_value_i,
  output logic signed [bmh_pkg::KEY_W-1:0] out_removed_value_o,
  output logic signed [bmh_pkg::KEY_W-1:0] out_min_value_o,
  output logic [bmh_pkg::COUNT_W-1:0]      out_count_o,
  output logic                             out_was_empty_o,
  output logic                             out_was_full_o
);

  logic signed [bmh_pkg::KEY_W-1:0] mem_q [bmh_pkg::CAPACITY];
  logic signed [bmh_pkg::KEY_W-1:0] rdata_a_q, rdata_b_q;
  logic [bmh_pkg::IDX_W-1:0]        raddr_a, raddr_b;

  logic [bmh_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [bmh_pkg::IDX_W-1:0]        idx_q, idx_d;
  logic signed [bmh_pkg::KEY_W-1:0] key_q, key_d;
  logic signed [bmh_pkg::KEY_W-1:0] root_q;

  logic signed [bmh_pkg::KEY_W-1:0] removed_q;
  logic                             empty_flag_q, full_flag_q;

  logic signed [bmh_pkg::KEY_W-1:0] res_removed_q, res_min_q;
  logic [bmh_pkg::COUNT_W-1:0]      res_count_q;
  logic                             res_empty_q, res_full_q;

  logic [bmh_pkg::IDX_W-1:0]        parent_idx;
  logic [bmh_pkg::CHILD_W-1:0]      left_idx, right_idx, cnt_ext;
  logic                             left_lt, right_ok, pick_right;
  logic signed [bmh_pkg::KEY_W-1:0] best_left;

  logic                             we;
  logic [bmh_pkg::IDX_W-1:0]        waddr;
  logic signed [bmh_pkg::KEY_W-1:0] wdata;

  assign parent_idx = (idx_q - bmh_pkg::IDX_W'(1)) >> 1;
  assign left_idx   = {1'b0, idx_q, 1'b0} + bmh_pkg::CHILD_W'(1);
  assign right_idx  = left_idx + bmh_pkg::CHILD_W'(1);
  assign cnt_ext    = bmh_pkg::CHILD_W'(cnt_q);

  // smaller child wins only when strictly below the moving key
  assign left_lt    = rdata_a_q < key_q;
  assign best_left  = left_lt ? rdata_a_q : key_q;
  assign right_ok   = right_idx < cnt_ext;
  assign pick_right = right_ok && (rdata_b_q < best_left);

  assign sts_o.full       = cnt_q == bmh_pkg::CNT_W'(bmh_pkg::CAPACITY);
  assign sts_o.empty      = cnt_q == '0;
  assign sts_o.at_root    = idx_q == '0;
  assign sts_o.up_less    = key_q < rdata_a_q;
  assign sts_o.leaf       = left_idx >= cnt_ext;
  assign sts_o.child_wins = left_lt || pick_right;

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd_i.rem_start) begin
      raddr_a = bmh_pkg::IDX_W'(cnt_q - bmh_pkg::CNT_W'(1));
    end else if (cmd_i.rd_parent) begin
      raddr_a = parent_idx;
    end else if (cmd_i.rd_children) begin
      raddr_a = left_idx[bmh_pkg::IDX_W-1:0];
      raddr_b = right_idx[bmh_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    we    = cmd_i.wr_key || cmd_i.wr_parent || cmd_i.wr_child;
    waddr = idx_q;
    wdata = key_q;
    if (cmd_i.wr_parent) begin
      wdata = rdata_a_q;
    end else if (cmd_i.wr_child) begin
      wdata = pick_right ? rdata_b_q : rdata_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_a_q <= mem_q[raddr_a];
    rdata_b_q <= mem_q[raddr_b];
  end

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    key_d = key_q;
    if (cmd_i.accept) begin
      key_d = in_value_i;
    end
    if (cmd_i.ins_start) begin
      idx_d = bmh_pkg::IDX_W'(cnt_q);
      cnt_d = cnt_q + bmh_pkg::CNT_W'(1);
    end
    if (cmd_i.rem_start) begin
      idx_d = '0;
      cnt_d = cnt_q - bmh_pkg::CNT_W'(1);
    end
    if (cmd_i.load_key) begin
      key_d = rdata_a_q;
    end
    if (cmd_i.wr_parent) begin
      idx_d = parent_idx;
    end
    if (cmd_i.wr_child) begin
      idx_d = pick_right ? right_idx[bmh_pkg::IDX_W-1:0] : left_idx[bmh_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    if (we && waddr == '0) begin
      root_q <= wdata;
    end
    if (cmd_i.accept) begin
      empty_flag_q <= (in_opcode_i == bmh_pkg::OP_REMOVE) && sts_o.empty;
      full_flag_q  <= (in_opcode_i == bmh_pkg::OP_INSERT) && sts_o.full;
      removed_q    <= ((in_opcode_i == bmh_pkg::OP_REMOVE) && !sts_o.empty) ? root_q : '0;
    end
    if (cmd_i.load_result) begin
      res_removed_q <= removed_q;
      res_min_q     <= sts_o.empty ? '0 : root_q;
      res_count_q   <= bmh_pkg::COUNT_W'(cnt_q);
      res_empty_q   <= empty_flag_q;
      res_full_q    <= full_flag_q;
    end
  end

  assign out_removed_value_o = res_removed_q;
  assign out_min_value_o     = res_min_q;
  assign out_count_o         = res_count_q;
  assign out_was_empty_o     = res_empty_q;
  assign out_was_full_o      = res_full_q;

  `BMH_ASSERT(a_cnt_bound, cnt_q <= bmh_pkg::CNT_W'(bmh_pkg::CAPACITY))
  `BMH_ASSERT_NEXT(a_root_tracks, we && waddr == '0, root_q == $past(wdata))
  `BMH_ASSERT_NEXT(a_cnt_inc, cmd_i.ins_start, cnt_q == $past(cnt_q) + bmh_pkg::CNT_W'(1))

endmodule

[rtl/bmh_ctrl.sv]
// sift sequencer and output handshake for the binary min-heap priority queue
`include "binary_min_heap_priority_queue_assert.svh"

module bmh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          in_opcode_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bmh_pkg::cmd_t cmd_o,
  input  bmh_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_CHK,
    ST_DN_CMP,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_opcode_i == bmh_pkg::OP_REMOVE) begin
            if (sts_i.empty) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.rem_start = 1'b1;
              state_d         = ST_DN_LOAD;
            end
          end else begin
            if (sts_i.full) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d         = ST_UP_CHK;
            end
          end
        end
      end
      ST_UP_CHK: begin
        if (sts_i.at_root) begin
          cmd_o.wr_key = 1'b1;
          state_d      = ST_FINISH;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (sts_i.up_less) begin
          cmd_o.wr_parent = 1'b1;
          state_d         = ST_UP_CHK;
        end else begin
          cmd_o.wr_key = 1'b1;
          state_d      = ST_FINISH;
        end
      end
      ST_DN_LOAD: begin
        cmd_o.load_key = 1'b1;
        state_d        = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (sts_i.leaf) begin
          cmd_o.wr_key = 1'b1;
          state_d      = ST_FINISH;
        end else begin
          cmd_o.rd_children = 1'b1;
          state_d           = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        if (sts_i.child_wins) begin
          cmd_o.wr_child = 1'b1;
          state_d        = ST_DN_CHK;
        end else begin
          cmd_o.wr_key = 1'b1;
          state_d      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BMH_ASSERT_NEXT(a_wrkey_done, cmd_o.wr_key, state_q == ST_FINISH)
  `BMH_ASSERT(a_rem_nonempty, cmd_o.rem_start |-> !sts_i.empty)
  `BMH_ASSERT(a_ins_room, cmd_o.ins_start |-> !sts_i.full)

endmodule

[rtl/binary_min_heap_priority_queue.sv]
// top level of the binary min-heap priority queue
//
// input channel: in_valid_i / in_stall_o carry one request, in_opcode_i
// (insert or remove) and the signed key in_value_i. a request is taken at an
// edge with in_valid_i high and in_stall_o low; in_stall_o is low only while
// the sequencer is idle, so one request is worked on at a time.
// output channel: out_valid_o / out_stall_i carry one result per request:
// removed key, new minimum (0 when empty), entry count and the empty / full
// flags. the result sits in an output register, so the next request can be
// taken while the previous result is still held by a stalled receiver.
// sift steps: each heap level a sift moves through is a read, then a
// compare and move, on the dual-read heap memory. an insert that stops
// below the root ends with one more read and compare; a remove first
// loads the last entry as its moving key and ends with one more read and
// compare when it stops above a leaf. a dropped insert or empty remove
// skips the sift. a stalled receiver holds the finished request back at
// the output slot. reset empties the heap at once; no clearing pass is run.

module binary_min_heap_priority_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             in_opcode_i,
  input  logic signed [bmh_pkg::KEY_W-1:0] in_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bmh_pkg::KEY_W-1:0] out_removed_value_o,
  output logic signed [bmh_pkg::KEY_W-1:0] out_min_value_o,
  output logic [bmh_pkg::COUNT_W-1:0]      out_count_o,
  output logic                             out_was_empty_o,
  output logic                             out_was_full_o
);

  bmh_pkg::cmd_t cmd;
  bmh_pkg::sts_t sts;

  bmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bmh_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .in_opcode_i         (in_opcode_i),
    .in_value_i          (in_value_i),
    .out_removed_value_o (out_removed_value_o),
    .out_min_value_o     (out_min_value_o),
    .out_count_o         (out_count_o),
    .out_was_empty_o     (out_was_empty_o),
    .out_was_full_o      (out_was_full_o)
  );

endmodule
